// ----- design/fbf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbf_pkg
// Shared constants, item codes and the arithmetic helper of the frame buffer
// blend and fill block.
// ----------------------------------------------------------------------------
package fbf_pkg;

    localparam int FBF_MAX_WIDTH  = 256;
    localparam int FBF_MAX_HEIGHT = 256;

    localparam int KIND_W  = 2;
    localparam int COORD_W = 16;
    localparam int COLOR_W = 32;
    localparam int CFG_W   = 9;
    localparam int CFG_IDX_W = 1;

    typedef logic [KIND_W-1:0]    kind_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam kind_t KIND_DRAW = 2'd0;
    localparam kind_t KIND_FILL = 2'd1;
    localparam kind_t KIND_READ = 2'd2;

    localparam cfg_idx_t REG_FRAME_WIDTH  = 1'b0;
    localparam cfg_idx_t REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] FRAME_SIZE_RST = 9'd256;

    // Exact floor(v / 255) for every v up to 255 * 255.
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = 17'(v) + 17'(v[15:8]) + 17'd1;
        return t[15:8];
    endfunction

endpackage

// ----- design/fbf_channels.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbf channels
// Valid/ready channels carrying request items and result items.
// ----------------------------------------------------------------------------
interface fbf_req_if import fbf_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic signed [COORD_W-1:0] x_pos;
    logic signed [COORD_W-1:0] y_pos;
    logic signed [COORD_W-1:0] x_end;
    logic signed [COORD_W-1:0] y_end;
    logic [COLOR_W-1:0]        color;

    modport source (output valid, kind, x_pos, y_pos, x_end, y_end, color, input ready);
    modport sink   (input valid, kind, x_pos, y_pos, x_end, y_end, color, output ready);
endinterface

interface fbf_rsp_if import fbf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pixel;
    logic               written;

    modport source (output valid, pixel, written, input ready);
    modport sink   (input valid, pixel, written, output ready);
endinterface

// ----- design/fbf_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbf_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module fbf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/framebuffer_blend_and_fill.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framebuffer_blend_and_fill
// Frame store of packed ARGB pixels with source-over draw, rectangle fill
// and pixel read, built around one read-modify-write RAM.
// ----------------------------------------------------------------------------
// Draw and read: the item passes the address, RAM read, product and
//   write-back states before its result is registered; the next item is
//   taken only once that result has moved into the free output register.
// Fill: the pixel walk covers the clipped width * height with one RAM read
//   per cycle, writing a pixel back only where it differs. Items that touch
//   no pixel skip straight to the result. Reset: a clearing pass writes zero
//   to all MAX_WIDTH * MAX_HEIGHT entries before the first item is taken.
module framebuffer_blend_and_fill import fbf_pkg::*; #(
    parameter int MAX_WIDTH  = FBF_MAX_WIDTH,
    parameter int MAX_HEIGHT = FBF_MAX_HEIGHT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  cfg_idx_t         cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    fbf_req_if.sink          req,
    fbf_rsp_if.source        rsp
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int SW    = 18;

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_PREP   = 4'd2;
    localparam logic [3:0] ST_RD     = 4'd3;
    localparam logic [3:0] ST_MUL    = 4'd4;
    localparam logic [3:0] ST_WB     = 4'd5;
    localparam logic [3:0] ST_FILL   = 4'd6;
    localparam logic [3:0] ST_FDRAIN = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    // Control state
    logic [3:0]       state_reg, state_next;
    logic [CFG_W-1:0] frame_width_reg, frame_width_next;
    logic [CFG_W-1:0] frame_height_reg, frame_height_next;
    logic [AW-1:0]    clr_addr_reg, clr_addr_next;
    logic             out_valid_reg, out_valid_next;
    logic             pend_valid_reg, pend_valid_next;

    // Payload
    kind_t            kind_reg, kind_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic [XW-1:0]    x_reg, x_next;
    logic [XW-1:0]    l_reg, l_next;
    logic [XW-1:0]    r_reg, r_next;
    logic [YW-1:0]    y_reg, y_next;
    logic [YW-1:0]    b_reg, b_next;
    logic [AW-1:0]    base_reg, base_next;
    logic [AW-1:0]    pend_addr_reg, pend_addr_next;
    logic             sticky_reg, sticky_next;
    logic [COLOR_W-1:0] old_reg, old_next;
    logic [15:0]      csum_reg [3];
    logic [15:0]      csum_next [3];
    logic [15:0]      asum_reg, asum_next;
    logic [COLOR_W-1:0] res_pix_reg, res_pix_next;
    logic             res_wr_reg, res_wr_next;
    logic [COLOR_W-1:0] out_pixel_reg, out_pixel_next;
    logic             out_written_reg, out_written_next;

    // RAM port signals
    logic               mem_we;
    logic [AW-1:0]      mem_wr_addr;
    logic [COLOR_W-1:0] mem_wr_data;
    logic [AW-1:0]      mem_rd_addr;
    logic [COLOR_W-1:0] mem_rd_data;

    // Effective frame size and request decode
    logic [WW-1:0]        eff_w;
    logic [HW-1:0]        eff_h;
    logic signed [SW-1:0] ew_s, eh_s;
    logic signed [SW-1:0] x0_s, y0_s, x1_s, y1_s;
    logic signed [SW-1:0] lo_x, hi_x, lo_y, hi_y;
    logic signed [SW-1:0] cl_l, cl_r, cl_t, cl_b;
    logic                 in_frame;
    logic                 fill_empty;
    logic [AW-1:0]        walk_addr;
    logic                 fill_diff;
    logic [7:0]           src_a;
    logic [7:0]           src_na;
    logic [COLOR_W-1:0]   blend_pix;
    logic [COLOR_W-1:0]   new_pix;

    fbf_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // A width or height of zero acts as one, anything above the maximum as the maximum.
    always_comb
    begin
        if (frame_width_reg == '0)
            eff_w = WW'(1);
        else if (32'(frame_width_reg) > MAX_WIDTH)
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(frame_width_reg);

        if (frame_height_reg == '0)
            eff_h = HW'(1);
        else if (32'(frame_height_reg) > MAX_HEIGHT)
            eff_h = HW'(MAX_HEIGHT);
        else
            eff_h = HW'(frame_height_reg);
    end

    assign ew_s = signed'(SW'(eff_w));
    assign eh_s = signed'(SW'(eff_h));
    assign x0_s = SW'(req.x_pos);
    assign y0_s = SW'(req.y_pos);
    assign x1_s = SW'(req.x_end);
    assign y1_s = SW'(req.y_end);

    assign in_frame = (x0_s >= 0) && (x0_s < ew_s) && (y0_s >= 0) && (y0_s < eh_s);

    assign lo_x = (x0_s < x1_s) ? x0_s : x1_s;
    assign hi_x = (x0_s < x1_s) ? x1_s : x0_s;
    assign lo_y = (y0_s < y1_s) ? y0_s : y1_s;
    assign hi_y = (y0_s < y1_s) ? y1_s : y0_s;
    assign cl_l = (lo_x < 0) ? '0 : lo_x;
    assign cl_t = (lo_y < 0) ? '0 : lo_y;
    assign cl_r = (hi_x > ew_s - SW'(1)) ? ew_s - SW'(1) : hi_x;
    assign cl_b = (hi_y > eh_s - SW'(1)) ? eh_s - SW'(1) : hi_y;
    assign fill_empty = (cl_l > cl_r) || (cl_t > cl_b);

    assign walk_addr = base_reg + AW'(x_reg);
    assign fill_diff = pend_valid_reg && (mem_rd_data != color_reg);

    // Blend from the registered channel sums.
    assign src_a  = color_reg[31:24];
    assign src_na = 8'd255 - src_a;
    assign blend_pix = {8'd255 - div255(asum_reg), div255(csum_reg[2]),
                        div255(csum_reg[1]), div255(csum_reg[0])};

    always_comb
    begin
        priority if (src_a == 8'd255)
            new_pix = color_reg;
        else if (src_a == 8'd0)
            new_pix = old_reg;
        else
            new_pix = blend_pix;
    end

    always_comb
    begin
        state_next        = state_reg;
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        clr_addr_next     = clr_addr_reg;
        out_valid_next    = out_valid_reg;
        pend_valid_next   = pend_valid_reg;
        kind_next         = kind_reg;
        color_next        = color_reg;
        x_next            = x_reg;
        l_next            = l_reg;
        r_next            = r_reg;
        y_next            = y_reg;
        b_next            = b_reg;
        base_next         = base_reg;
        pend_addr_next    = pend_addr_reg;
        sticky_next       = sticky_reg;
        old_next          = old_reg;
        csum_next         = csum_reg;
        asum_next         = asum_reg;
        res_pix_next      = res_pix_reg;
        res_wr_next       = res_wr_reg;
        out_pixel_next    = out_pixel_reg;
        out_written_next  = out_written_reg;

        mem_we      = 1'b0;
        mem_wr_addr = pend_addr_reg;
        mem_wr_data = color_reg;
        mem_rd_addr = walk_addr;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_next  = cfg_data;
                REG_FRAME_HEIGHT: frame_height_next = cfg_data;
            endcase
        end

        if (rsp.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we      = 1'b1;
                mem_wr_addr = clr_addr_reg;
                mem_wr_data = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1))
                    state_next = ST_IDLE;
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next    = req.kind;
                    color_next   = req.color;
                    sticky_next  = 1'b0;
                    res_pix_next = '0;
                    res_wr_next  = 1'b0;
                    l_next       = cl_l[XW-1:0];
                    r_next       = cl_r[XW-1:0];
                    b_next       = cl_b[YW-1:0];
                    if (req.kind == KIND_FILL)
                    begin
                        x_next     = cl_l[XW-1:0];
                        y_next     = cl_t[YW-1:0];
                        state_next = fill_empty ? ST_DONE : ST_PREP;
                    end
                    else
                    begin
                        x_next     = x0_s[XW-1:0];
                        y_next     = y0_s[YW-1:0];
                        state_next = ((req.kind == KIND_DRAW || req.kind == KIND_READ)
                                      && in_frame) ? ST_PREP : ST_DONE;
                    end
                end
            end

            ST_PREP:
            begin
                base_next  = AW'(eff_w) * AW'(y_reg);
                state_next = (kind_reg == KIND_FILL) ? ST_FILL : ST_RD;
            end

            ST_RD:
            begin
                state_next = ST_MUL;
            end

            ST_MUL:
            begin
                old_next = mem_rd_data;
                for (int i = 0; i < 3; i++)
                begin
                    csum_next[i] = 16'(src_na) * 16'(mem_rd_data[8*i +: 8])
                                 + 16'(src_a) * 16'(color_reg[8*i +: 8]);
                end
                asum_next  = 16'(src_na) * 16'(8'd255 - mem_rd_data[31:24]);
                state_next = ST_WB;
            end

            ST_WB:
            begin
                if (kind_reg == KIND_DRAW)
                begin
                    mem_we       = (new_pix != old_reg);
                    mem_wr_addr  = walk_addr;
                    mem_wr_data  = new_pix;
                    res_pix_next = new_pix;
                    res_wr_next  = (new_pix != old_reg);
                end
                else
                begin
                    res_pix_next = old_reg;
                end
                state_next = ST_DONE;
            end

            ST_FILL:
            begin
                // Read one pixel per cycle; the previous read is compared and, if it
                // differs, rewritten behind it, never at the address being read.
                pend_valid_next = 1'b1;
                pend_addr_next  = walk_addr;
                if (fill_diff)
                begin
                    mem_we      = 1'b1;
                    sticky_next = 1'b1;
                end
                if (x_reg == r_reg)
                begin
                    if (y_reg == b_reg)
                    begin
                        state_next = ST_FDRAIN;
                    end
                    else
                    begin
                        x_next    = l_reg;
                        y_next    = y_reg + YW'(1);
                        base_next = base_reg + AW'(eff_w);
                    end
                end
                else
                begin
                    x_next = x_reg + XW'(1);
                end
            end

            ST_FDRAIN:
            begin
                mem_we          = fill_diff;
                pend_valid_next = 1'b0;
                res_wr_next     = sticky_reg || fill_diff;
                state_next      = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_pixel_next   = res_pix_reg;
                    out_written_next = res_wr_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            frame_width_reg  <= FRAME_SIZE_RST;
            frame_height_reg <= FRAME_SIZE_RST;
            clr_addr_reg     <= '0;
            out_valid_reg    <= 1'b0;
            pend_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            clr_addr_reg     <= clr_addr_next;
            out_valid_reg    <= out_valid_next;
            pend_valid_reg   <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        color_reg       <= color_next;
        x_reg           <= x_next;
        l_reg           <= l_next;
        r_reg           <= r_next;
        y_reg           <= y_next;
        b_reg           <= b_next;
        base_reg        <= base_next;
        pend_addr_reg   <= pend_addr_next;
        sticky_reg      <= sticky_next;
        old_reg         <= old_next;
        csum_reg        <= csum_next;
        asum_reg        <= asum_next;
        res_pix_reg     <= res_pix_next;
        res_wr_reg      <= res_wr_next;
        out_pixel_reg   <= out_pixel_next;
        out_written_reg <= out_written_next;
    end

    assign req.ready   = (state_reg == ST_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.pixel   = out_pixel_reg;
    assign rsp.written = out_written_reg;

    // The store is never written while the block waits for an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("frame store written while idle");

    // Every write lands inside the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (mem_wr_addr <= AW'(DEPTH - 1)))
        else $error("frame store write beyond its depth");

    // The fill walk stays inside the clipped columns.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> (x_reg >= l_reg && x_reg <= r_reg))
        else $error("fill column left the clipped rectangle");

    // A write during the fill walk always goes to the entry read in the cycle before.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL && mem_we) |-> (mem_wr_addr == $past(mem_rd_addr)))
        else $error("fill write does not match the preceding read");

endmodule

// ----- tb/frame_pixel_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_pixel_checker
// Watches the request, result and register ports of the frame buffer,
// keeps its own copy of the frame store and frame size, works out the
// result of every request beat and compares it with the result beats.
// ----------------------------------------------------------------------------
module frame_pixel_checker import fbf_pkg::*; #(
    parameter int MAX_WIDTH  = FBF_MAX_WIDTH,
    parameter int MAX_HEIGHT = FBF_MAX_HEIGHT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  cfg_idx_t         cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    fbf_req_if               req,
    fbf_rsp_if               rsp,
    output int               mismatches,
    output int               outstanding
);

    typedef struct packed {
        logic [COLOR_W-1:0] pixel;
        logic               written;
    } pixel_reply_t;

    logic [COLOR_W-1:0] pixel_mem [MAX_WIDTH*MAX_HEIGHT];
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    pixel_reply_t       replies_due [$];

    function automatic int clamp_size(input logic [CFG_W-1:0] value, input int limit);
        if (value == 0)
        begin
            return 1;
        end
        if (int'(value) > limit)
        begin
            return limit;
        end
        return int'(value);
    endfunction

    // Source-over of a partly transparent color onto the stored pixel.
    function automatic logic [COLOR_W-1:0] blend_over(input logic [COLOR_W-1:0] dst,
                                                      input logic [COLOR_W-1:0] src);
        logic [COLOR_W-1:0] mix;
        int                 a;
        int                 na;
        a  = int'(src[31:24]);
        na = 255 - a;
        mix[31:24] = 8'(255 - (255 - int'(dst[31:24])) * na / 255);
        for (int c = 0; c < 3; c++)
        begin
            mix[8*c +: 8] = 8'((na * int'(dst[8*c +: 8]) + a * int'(src[8*c +: 8])) / 255);
        end
        return mix;
    endfunction

    function automatic pixel_reply_t apply_item(input kind_t kind, input int x0, input int y0,
                                                input int x1, input int y1,
                                                input logic [COLOR_W-1:0] color);
        pixel_reply_t       res;
        int                 w;
        int                 h;
        int                 idx;
        int                 l;
        int                 r;
        int                 t;
        int                 b;
        logic [COLOR_W-1:0] old;
        res.pixel   = '0;
        res.written = 1'b0;
        w = clamp_size(width_reg, MAX_WIDTH);
        h = clamp_size(height_reg, MAX_HEIGHT);
        if (kind == KIND_DRAW || kind == KIND_READ)
        begin
            if (x0 >= 0 && x0 < w && y0 >= 0 && y0 < h)
            begin
                idx       = x0 + w * y0;
                old       = pixel_mem[idx];
                res.pixel = old;
                if (kind == KIND_DRAW)
                begin
                    if (color[31:24] == 8'hff)
                    begin
                        res.pixel = color;
                    end
                    else if (color[31:24] != 8'h00)
                    begin
                        res.pixel = blend_over(old, color);
                    end
                    if (res.pixel != old)
                    begin
                        pixel_mem[idx] = res.pixel;
                        res.written    = 1'b1;
                    end
                end
            end
        end
        else if (kind == KIND_FILL)
        begin
            l = (x0 < x1) ? x0 : x1;
            r = (x0 < x1) ? x1 : x0;
            t = (y0 < y1) ? y0 : y1;
            b = (y0 < y1) ? y1 : y0;
            if (l < 0) l = 0;
            if (t < 0) t = 0;
            if (r > w - 1) r = w - 1;
            if (b > h - 1) b = h - 1;
            for (int yy = t; yy <= b; yy++)
            begin
                for (int xx = l; xx <= r; xx++)
                begin
                    if (pixel_mem[xx + w * yy] != color)
                    begin
                        pixel_mem[xx + w * yy] = color;
                        res.written            = 1'b1;
                    end
                end
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_reply_t due;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WIDTH * MAX_HEIGHT; i++)
            begin
                pixel_mem[i] = '0;
            end
            width_reg  = FRAME_SIZE_RST;
            height_reg = FRAME_SIZE_RST;
            replies_due.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_FRAME_WIDTH)
                begin
                    width_reg = cfg_data;
                end
                else if (cfg_index == REG_FRAME_HEIGHT)
                begin
                    height_reg = cfg_data;
                end
            end
            if (rsp.valid && rsp.ready)
            begin
                if (replies_due.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, got pixel %08h written %0b",
                             $time, rsp.pixel, rsp.written);
                    mismatches++;
                end
                else
                begin
                    due = replies_due.pop_front();
                    if (rsp.pixel !== due.pixel)
                    begin
                        $display("%0t: pixel expected %08h, got %08h",
                                 $time, due.pixel, rsp.pixel);
                        mismatches++;
                    end
                    if (rsp.written !== due.written)
                    begin
                        $display("%0t: written expected %0b, got %0b",
                                 $time, due.written, rsp.written);
                        mismatches++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                replies_due.push_back(apply_item(req.kind, int'(req.x_pos), int'(req.y_pos),
                                                 int'(req.x_end), int'(req.y_end), req.color));
            end
            outstanding = replies_due.size();
        end
    end

endmodule

// ----- tb/framebuffer_blend_and_fill_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framebuffer_blend_and_fill_test
// Drives draw, fill and read beats into the frame buffer under several frame
// sizes and backpressure patterns; the checker beside the block predicts and
// compares every result beat, and this module gives the verdict.
// ----------------------------------------------------------------------------
module framebuffer_blend_and_fill_test;
    import fbf_pkg::*;

    localparam kind_t KIND_UNUSED    = 2'd3;
    localparam int    WATCHDOG_LIMIT = 400000;
    localparam int    SETTLE_CYCLES  = 12;
    localparam int    PHASE_ITEMS    = 216;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    cfg_idx_t         cfg_index;
    logic [CFG_W-1:0] cfg_data;
    int               mismatch_count;
    int               outstanding;
    int               tx_idle_pct;
    int               rx_idle_pct;
    int               idle_cycles;
    int               cur_w;
    int               cur_h;

    fbf_req_if req_ch ();
    fbf_rsp_if rsp_ch ();

    framebuffer_blend_and_fill dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    frame_pixel_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatch_count),
        .outstanding (outstanding)
    );

    always #4 clk = ~clk;

    always @(negedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Counts cycles in which no beat moves on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic issue_item(input kind_t kind, input int x0, input int y0,
                              input int x1, input int y1, input logic [COLOR_W-1:0] color);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind  <= kind;
        req_ch.x_pos <= 16'(x0);
        req_ch.y_pos <= 16'(y0);
        req_ch.x_end <= 16'(x1);
        req_ch.y_end <= 16'(y1);
        req_ch.color <= color;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t index, input logic [CFG_W-1:0] value);
        int eff;
        int limit;
        drain_results();
        limit = (index == REG_FRAME_WIDTH) ? FBF_MAX_WIDTH : FBF_MAX_HEIGHT;
        eff = (value == 0) ? 1 : (int'(value) > limit ? limit : int'(value));
        if (index == REG_FRAME_WIDTH)
        begin
            cur_w = eff;
        end
        else
        begin
            cur_h = eff;
        end
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] pick_size();
        int sel;
        sel = $urandom_range(9);
        if (sel < 7) return CFG_W'($urandom_range(20, 1));
        if (sel == 7) return '0;
        if (sel == 8) return CFG_W'($urandom_range(511, 257));
        return CFG_W'($urandom_range(256, 21));
    endfunction

    // Mostly just around the frame, sometimes anywhere in the 16-bit range.
    function automatic int pick_coord(input int span);
        if ($urandom_range(7) == 0) return int'($signed(16'($urandom)));
        return int'($urandom_range(span + 7)) - 4;
    endfunction

    function automatic logic [COLOR_W-1:0] pick_color();
        logic [COLOR_W-1:0] c;
        c = $urandom;
        case ($urandom_range(5))
            0: c[31:24] = 8'h00;
            1: c[31:24] = 8'hff;
            2: c = {8'hff, 24'($urandom_range(3) * 24'h404040)};
            default: ;
        endcase
        return c;
    endfunction

    task automatic random_item();
        int sel;
        int x0;
        int y0;
        int x1;
        int y1;
        sel = $urandom_range(19);
        x1  = $urandom;
        y1  = $urandom;
        if (sel < 13 && $urandom_range(3) != 0)
        begin
            x0 = $urandom_range(cur_w - 1);
            y0 = $urandom_range(cur_h - 1);
        end
        else
        begin
            x0 = pick_coord(cur_w);
            y0 = pick_coord(cur_h);
        end
        if (sel < 9)
        begin
            issue_item(KIND_DRAW, x0, y0, x1, y1, pick_color());
        end
        else if (sel < 14)
        begin
            issue_item(KIND_READ, x0, y0, x1, y1, $urandom);
        end
        else if (sel < 19)
        begin
            // Large frames only get small rectangles to keep the walk short.
            if (cur_w * cur_h > 1024)
            begin
                x0 = int'($urandom_range(cur_w + 7)) - 4;
                y0 = int'($urandom_range(cur_h + 7)) - 4;
                x1 = x0 + int'($urandom_range(12)) - 6;
                y1 = y0 + int'($urandom_range(12)) - 6;
            end
            else
            begin
                x1 = pick_coord(cur_w);
                y1 = pick_coord(cur_h);
            end
            issue_item(KIND_FILL, x0, y0, x1, y1, pick_color());
        end
        else
        begin
            issue_item(KIND_UNUSED, x0, y0, x1, y1, $urandom);
        end
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_FRAME_WIDTH;
        cfg_data     = '0;
        req_ch.valid = 1'b0;
        req_ch.kind  = KIND_DRAW;
        req_ch.x_pos = '0;
        req_ch.y_pos = '0;
        req_ch.x_end = '0;
        req_ch.y_end = '0;
        req_ch.color = '0;
        rsp_ch.ready = 1'b0;
        tx_idle_pct  = 12;
        rx_idle_pct  = 87;
        idle_cycles  = 0;
        cur_w        = FBF_MAX_WIDTH;
        cur_h        = FBF_MAX_HEIGHT;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed beats on the full-size frame.
        issue_item(KIND_DRAW, 0, 0, 0, 0, 32'hff112233);
        issue_item(KIND_DRAW, 0, 0, 0, 0, 32'hff112233);
        issue_item(KIND_DRAW, 0, 0, 0, 0, 32'h00ffffff);
        issue_item(KIND_DRAW, 0, 0, 0, 0, 32'h80ffffff);
        issue_item(KIND_DRAW, 255, 255, 0, 0, 32'h01abcdef);
        issue_item(KIND_DRAW, 256, 0, 0, 0, 32'hffffffff);
        issue_item(KIND_DRAW, 0, 256, 0, 0, 32'hffffffff);
        issue_item(KIND_DRAW, -32768, 32767, -1, -1, 32'hfe000000);
        issue_item(KIND_READ, 32767, -32768, 0, 0, 32'hffffffff);
        issue_item(KIND_READ, 0, 0, 0, 0, 32'h0);
        issue_item(KIND_READ, 255, 255, 0, 0, 32'h0);
        issue_item(KIND_UNUSED, 1, 1, 2, 2, 32'hffffffff);
        issue_item(KIND_FILL, 10, 12, 3, 4, 32'hdeadbeef);
        issue_item(KIND_FILL, 3, 4, 10, 12, 32'hdeadbeef);
        issue_item(KIND_FILL, -5, -9, -1, -2, 32'h11111111);
        issue_item(KIND_FILL, 300, 5, 400, 9, 32'h22222222);
        issue_item(KIND_FILL, -32768, -32768, 32767, 32767, 32'h12345678);
        issue_item(KIND_READ, 128, 77, 0, 0, 32'h0);

        // Register extremes; the stored pixels keep their indices.
        write_reg(REG_FRAME_WIDTH, 9'd0);
        write_reg(REG_FRAME_HEIGHT, 9'd511);
        issue_item(KIND_DRAW, 0, 5, 0, 0, 32'h7f00ff00);
        issue_item(KIND_DRAW, 1, 5, 0, 0, 32'hff00ff00);
        issue_item(KIND_FILL, 32767, 32767, -32768, -32768, 32'h00000000);
        write_reg(REG_FRAME_WIDTH, 9'd511);
        write_reg(REG_FRAME_HEIGHT, 9'd1);
        issue_item(KIND_READ, 200, 0, 0, 0, 32'h0);
        write_reg(REG_FRAME_WIDTH, 9'd256);
        write_reg(REG_FRAME_HEIGHT, 9'd256);
        issue_item(KIND_READ, 0, 5, 0, 0, 32'h0);

        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 12 : (phase == 1 ? 87 : 0);
            rx_idle_pct = (phase == 0) ? 87 : (phase == 1 ? 12 : 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 54 == 0)
                begin
                    write_reg(REG_FRAME_WIDTH, pick_size());
                    write_reg(REG_FRAME_HEIGHT, pick_size());
                end
                random_item();
            end
        end

        req_ch.valid <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && outstanding == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/fbf_pkg.sv
design/fbf_channels.sv
design/fbf_ram.sv
design/framebuffer_blend_and_fill.sv
tb/frame_pixel_checker.sv
tb/framebuffer_blend_and_fill_test.sv
